// File: rtl/swm_pkg.sv
// Shared constants and types for the sliding window maximum block.
package swm_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W      = IDX_W + 1;
    localparam int DATA_W     = 32;
    localparam int WLEN_W     = 7;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd3;

    // One deque entry as a cell holds it and shows it to its left neighbor.
    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     vld;
    } cand_t;

    // Per-item control broadcast to every cell.
    typedef struct packed {
        logic signed [DATA_W-1:0] x;       // incoming sample
        logic                     start;   // new sequence, drop all entries
        logic                     expire;  // pop the front before compare
        logic                     step;    // item accepted this cycle
    } cell_ctl_t;

endpackage

// File: rtl/sliding_window_maximum_core.sv
// Top level: sliding window maximum over a signed sample stream.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid / s_tready  s_tdata[31:0] sample, s_tuser start_req
//  m_       out  m_tvalid / m_tready  m_tdata[31:0] window_max
//  cfg_     in   cfg_wr_en            cfg_wr_data[6:0] window_len
//
//  One item per cycle. The deque is a row of MAX_WINDOW cells that pop,
//  compare and push in the same cycle; the history ring read for the next
//  item is issued at the accept edge, so nothing stalls between items.
//  A config write holds s_tready low in the next cycle while the ring read
//  address is refetched with the new window length.
//  aresetn is synchronous, active low; no memory clearing pass is needed.
//  s_tready also drops while a result sits in m_tdata and m_tready is low.
module sliding_window_maximum_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,     // [31:0] sample
    input  logic                        s_tuser,     // [0] start_req
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,     // [31:0] window_max
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [swm_pkg::WLEN_W-1:0]  cfg_wr_data  // window_len
);

    localparam int N = swm_pkg::MAX_WINDOW;

    // ---------------- registers ----------------
    logic [swm_pkg::WLEN_W-1:0]        wlen_reg;
    logic                              stale_reg;   // ring read not yet valid
    logic [swm_pkg::IDX_W-1:0]         ptr_reg, ptr_next;
    logic [swm_pkg::CNT_W-1:0]         seen_reg, seen_next;
    logic                              out_vld_reg;
    logic signed [swm_pkg::DATA_W-1:0] out_data_reg;

    // ---------------- item datapath ----------------
    logic                              accept, start, expire, full, emit;
    logic signed [swm_pkg::DATA_W-1:0] x, old_val, front;
    logic [swm_pkg::CNT_W-1:0]         w_eff, seen_base, rd_sum;
    logic [swm_pkg::IDX_W-1:0]         ptr_base, ptr_inc, rd_addr;
    swm_pkg::cell_ctl_t                ctl;
    swm_pkg::cand_t                    cand_q   [N];
    swm_pkg::cand_t                    right_in [N];
    logic [N-1:0]                      keep_vec, left_keep, vld_vec;
    logic signed [swm_pkg::DATA_W-1:0] val_nx   [N];

    assign s_tready = !stale_reg && (!out_vld_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign start    = s_tuser;
    assign x        = signed'(s_tdata);

    // Window length clamped to 1..MAX_WINDOW.
    always_comb begin
        if (wlen_reg == '0) begin
            w_eff = swm_pkg::CNT_W'(1);
        end else if (int'(wlen_reg) > N) begin
            w_eff = swm_pkg::CNT_W'(N);
        end else begin
            w_eff = swm_pkg::CNT_W'(wlen_reg);
        end
    end

    // A start clears count and ring position before the sample is taken.
    assign seen_base = start ? '0 : seen_reg;
    assign ptr_base  = start ? '0 : ptr_reg;
    assign ptr_inc   = (int'(ptr_base) == N - 1) ? '0 : ptr_base + 1'b1;

    assign seen_next = (int'(seen_base) < N) ? seen_base + 1'b1 : seen_base;
    assign emit      = (seen_next >= w_eff);

    // Front pops when the sample leaving the window equals it.
    assign expire = !start && (seen_base >= w_eff) && cand_q[0].vld
                    && (cand_q[0].val == old_val);
    // Deque still full after the compare: front gives way to the push.
    assign full   = !expire && (&keep_vec);

    assign ctl.x      = x;
    assign ctl.start  = start;
    assign ctl.expire = expire;
    assign ctl.step   = accept;

    // ---------------- cell row ----------------
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            if (gi == N - 1) begin : g_tail
                // past the back: the new sample, never a live entry
                assign right_in[gi].val = x;
                assign right_in[gi].vld = 1'b0;
            end else begin : g_mid
                assign right_in[gi] = cand_q[gi+1];
            end
            if (gi == 0) begin : g_head
                assign left_keep[gi] = 1'b1;
            end else begin : g_body
                assign left_keep[gi] = keep_vec[gi-1];
            end
            assign vld_vec[gi] = cand_q[gi].vld;

            swm_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctl_i       (ctl),
                .full_i      (full),
                .right_i     (right_in[gi]),
                .left_keep_i (left_keep[gi]),
                .self_o      (cand_q[gi]),
                .keep_o      (keep_vec[gi]),
                .val_next_o  (val_nx[gi])
            );
        end
    endgenerate

    assign front = val_nx[0];

    // ---------------- history ring ----------------
    // Read address for the next item: w_eff samples behind the write slot.
    assign ptr_next = accept ? ptr_inc : ptr_reg;
    assign rd_sum   = (swm_pkg::CNT_W'(ptr_next) >= w_eff)
                    ? swm_pkg::CNT_W'(ptr_next) - w_eff
                    : swm_pkg::CNT_W'(ptr_next) + swm_pkg::CNT_W'(N) - w_eff;
    assign rd_addr  = rd_sum[swm_pkg::IDX_W-1:0];

    swm_hist u_hist (
        .aclk      (aclk),
        .wr_en_i   (accept),
        .wr_addr_i (ptr_base),
        .wr_data_i (x),
        .rd_addr_i (rd_addr),
        .rd_data_o (old_val)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg    <= swm_pkg::WLEN_RESET;
            stale_reg   <= 1'b0;
            ptr_reg     <= '0;
            seen_reg    <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                wlen_reg <= cfg_wr_data;
            end
            stale_reg <= cfg_wr_en;
            ptr_reg   <= ptr_next;
            if (accept) begin
                seen_reg <= seen_next;
            end
            if (accept && emit) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            out_data_reg <= front;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- assertions ----------------
    // live entries always form a prefix of the row
    a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({1'b0, vld_vec} + {{N{1'b0}}, 1'b1}))
        else $error("deque entries not contiguous from the front");

    // a fresh result always has a live front entry behind it
    a_front: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> cand_q[0].vld)
        else $error("result issued with empty deque");

    // sample count saturates at the window capacity
    a_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(seen_reg) <= N)
        else $error("sample count beyond capacity");

    // no item taken while the ring read still uses the old window length
    a_stale: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("item accepted right after config write");

endmodule

// File: rtl/swm_cell.sv
// One deque cell: holds a candidate, shifts left on pop, compares, takes a push.
module swm_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  swm_pkg::cell_ctl_t               ctl_i,
    input  logic                             full_i,      // deque full, drop front
    input  swm_pkg::cand_t                   right_i,     // right neighbor's entry
    input  logic                             left_keep_i, // left neighbor keeps its entry
    output swm_pkg::cand_t                   self_o,
    output logic                             keep_o,
    output logic signed [swm_pkg::DATA_W-1:0] val_next_o
);

    logic signed [swm_pkg::DATA_W-1:0] val_reg, val_next;
    logic                              vld_reg, vld_next;
    logic signed [swm_pkg::DATA_W-1:0] val_sh;
    logic                              vld_own, vld_sh, keep, place;

    // Entry after the optional front pop.
    assign vld_own = vld_reg && !ctl_i.start;
    assign val_sh  = ctl_i.expire ? right_i.val : val_reg;
    assign vld_sh  = ctl_i.expire ? right_i.vld : vld_own;

    // Entries strictly below the new sample leave from the back.
    assign keep  = vld_sh && !(ctl_i.x > val_sh);
    assign place = !keep && left_keep_i;

    always_comb begin
        if (full_i) begin
            val_next = right_i.val;
            vld_next = 1'b1;
        end else begin
            val_next = keep ? val_sh : ctl_i.x;
            vld_next = keep || place;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ctl_i.step) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_i.step) begin
            val_reg <= val_next;
        end
    end

    assign self_o.val = val_reg;
    assign self_o.vld = vld_reg;
    assign keep_o     = keep;
    assign val_next_o = val_next;

endmodule

// File: rtl/swm_hist.sv
// Sample history ring: one write port, one registered read port with bypass.
module swm_hist (
    input  logic                              aclk,
    input  logic                              wr_en_i,
    input  logic [swm_pkg::IDX_W-1:0]         wr_addr_i,
    input  logic signed [swm_pkg::DATA_W-1:0] wr_data_i,
    input  logic [swm_pkg::IDX_W-1:0]         rd_addr_i,
    output logic signed [swm_pkg::DATA_W-1:0] rd_data_o
);

    logic signed [swm_pkg::DATA_W-1:0] mem [swm_pkg::MAX_WINDOW];
    logic signed [swm_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en_i) begin
            mem[wr_addr_i] <= wr_data_i;
        end
        // same-slot read sees the value written this cycle
        if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
            rd_data_reg <= wr_data_i;
        end else begin
            rd_data_reg <= mem[rd_addr_i];
        end
    end

    assign rd_data_o = rd_data_reg;

endmodule

// File: tb/sliding_window_maximum_core_tb.sv
`timescale 1ns / 100ps
// Testbench for sliding_window_maximum_core: directed and random streams vs a predictor.
module sliding_window_maximum_core_tb;

    typedef logic signed [swm_pkg::DATA_W-1:0] sample_t;

    // how the next random sample relates to the previous one
    typedef enum int {
        SHAPE_WIDE,
        SHAPE_NARROW,
        SHAPE_RISING,
        SHAPE_FALLING,
        SHAPE_EXTREME
    } shape_t;

    localparam sample_t S_MIN = {1'b1, {(swm_pkg::DATA_W-1){1'b0}}};
    localparam sample_t S_MAX = {1'b0, {(swm_pkg::DATA_W-1){1'b1}}};
    // cycles an item may still be in the pipe after the last result
    localparam int SETTLE_CYCLES = 6;
    // predicted results not yet taken; only a few are ever pending
    localparam int WANT_DEPTH = 64;

    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        s_tvalid    = 1'b0;
    logic                        s_tready;
    logic [swm_pkg::DATA_W-1:0]  s_tdata     = '0;
    logic                        s_tuser     = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready    = 1'b1;
    logic [swm_pkg::DATA_W-1:0]  m_tdata;
    logic                        cfg_wr_en   = 1'b0;
    logic [swm_pkg::WLEN_W-1:0]  cfg_wr_data = '0;

    // predictor state: window length, candidate deque, sample history
    logic [swm_pkg::WLEN_W-1:0] win_reg = swm_pkg::WLEN_RESET;
    sample_t           cand_val [swm_pkg::MAX_WINDOW];
    sample_t           hist_val [swm_pkg::MAX_WINDOW];
    int                cand_head = 0;
    int                cand_cnt  = 0;
    int                hist_ptr  = 0;
    int                seen      = 0;

    // predicted window max values, in order
    sample_t           want_fifo [WANT_DEPTH];
    int                want_wr = 0;
    int                want_rd = 0;
    int                mismatch_count = 0;

    // sender bursts and receiver stall pattern
    int                gap_max    = 0;
    int                burst_left = 0;
    bit                stall_on   = 1'b0;
    bit                rdy_phase  = 1'b1;
    int                run_left   = 0;

    sliding_window_maximum_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // [31:0] sample
        .s_tuser     (s_tuser),     // [0] start_req
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // [31:0] window_max
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Advance the window state by one item; queue the window max if one is due.
    function automatic void window_max_predict(input sample_t x, input logic start);
        int      w;
        sample_t leaving;
        w = (win_reg == 0) ? 1 :
            (win_reg > swm_pkg::MAX_WINDOW) ? swm_pkg::MAX_WINDOW : int'(win_reg);
        if (start) begin
            cand_head = 0;
            cand_cnt  = 0;
            hist_ptr  = 0;
            seen      = 0;
        end
        // drop the front if it is the sample falling out of the window
        if (seen >= w) begin
            leaving = hist_val[(hist_ptr + swm_pkg::MAX_WINDOW - w) % swm_pkg::MAX_WINDOW];
            if (cand_cnt > 0 && cand_val[cand_head] == leaving) begin
                cand_head = (cand_head + 1) % swm_pkg::MAX_WINDOW;
                cand_cnt--;
            end
        end
        while (cand_cnt > 0 &&
               x > cand_val[(cand_head + cand_cnt - 1) % swm_pkg::MAX_WINDOW])
            cand_cnt--;
        // full deque only after a window change mid-sequence: lose the front
        if (cand_cnt >= swm_pkg::MAX_WINDOW) begin
            cand_head = (cand_head + 1) % swm_pkg::MAX_WINDOW;
            cand_cnt--;
        end
        cand_val[(cand_head + cand_cnt) % swm_pkg::MAX_WINDOW] = x;
        cand_cnt++;
        hist_val[hist_ptr] = x;
        hist_ptr = (hist_ptr + 1) % swm_pkg::MAX_WINDOW;
        if (seen < swm_pkg::MAX_WINDOW) seen++;
        if (seen >= w) begin
            want_fifo[want_wr % WANT_DEPTH] = cand_val[cand_head];
            want_wr++;
        end
    endfunction

    function automatic sample_t gen_sample(input shape_t shape, input sample_t prev);
        unique case (shape)
            SHAPE_WIDE:    return sample_t'($urandom);
            SHAPE_NARROW:  return sample_t'($urandom_range(0, 7)) - 4;
            SHAPE_RISING:  return prev + sample_t'($urandom_range(0, 3));
            SHAPE_FALLING: return prev - sample_t'($urandom_range(1, 3));
            default: begin
                unique case ($urandom_range(0, 3))
                    0:       return S_MIN;
                    1:       return S_MAX;
                    2:       return sample_t'(0);
                    default: return sample_t'(-1);
                endcase
            end
        endcase
    endfunction

    // One item: optional gap at a burst boundary, then hold until accepted.
    task automatic send_item(input sample_t x, input logic start);
        int n;
        if (burst_left == 0) begin
            n = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            repeat (n) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        window_max_predict(x, start);
    endtask

    // Sender stops until every predicted result has been taken.
    task automatic wait_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (want_wr != want_rd) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [swm_pkg::WLEN_W-1:0] len);
        wait_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        win_reg = len;
    endtask

    // Receiver: alternating ready and stall runs of random length.
    always @(negedge aclk) begin
        if (!stall_on) begin
            m_tready <= 1'b1;
        end else begin
            if (run_left == 0) begin
                rdy_phase = !rdy_phase;
                run_left  = rdy_phase ? $urandom_range(1, 12) : $urandom_range(1, 8);
            end
            run_left--;
            m_tready <= rdy_phase;
        end
    end

    always @(posedge aclk) begin : check_results
        sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (want_wr == want_rd) begin
                report_mismatch($sformatf("unexpected window_max %0d", $signed(m_tdata)));
            end else begin
                want = want_fifo[want_rd % WANT_DEPTH];
                want_rd++;
                if (m_tdata !== want)
                    report_mismatch($sformatf("window_max %0d, predicted %0d",
                                              $signed(m_tdata), want));
            end
        end
    end

    // Reset window length 3: extremes, duplicates, a restart mid-run.
    task automatic test_default_window();
        send_item(S_MIN, 1'b1);
        send_item(S_MAX, 1'b0);
        send_item(sample_t'(0), 1'b0);
        send_item(sample_t'(-1), 1'b0);
        send_item(sample_t'(-1), 1'b0);
        send_item(sample_t'(-1), 1'b0);
        send_item(S_MAX, 1'b0);
        send_item(S_MAX, 1'b0);
        send_item(sample_t'(5), 1'b0);
        send_item(sample_t'(4), 1'b0);
        send_item(sample_t'(3), 1'b0);
        send_item(sample_t'(7), 1'b1);
        send_item(sample_t'(1), 1'b0);
        send_item(sample_t'(2), 1'b0);
    endtask

    // Window 1 and window 0, which behaves as 1.
    task automatic test_window_limits();
        write_window(swm_pkg::WLEN_W'(1));
        send_item(S_MAX, 1'b1);
        send_item(S_MIN, 1'b0);
        send_item(sample_t'(9), 1'b0);
        write_window(swm_pkg::WLEN_W'(0));
        send_item(sample_t'(-5), 1'b0);
        send_item(S_MIN, 1'b1);
        send_item(S_MAX, 1'b0);
    endtask

    // Length changes inside a sequence, including a full deque on push.
    task automatic test_window_change();
        sample_t v;
        gap_max  = 4;
        stall_on = 1'b1;
        write_window(swm_pkg::WLEN_W'(3));
        v = gen_sample(SHAPE_WIDE, sample_t'(0));
        send_item(v, 1'b1);
        repeat (4) begin
            v = gen_sample(SHAPE_NARROW, v);
            send_item(v, 1'b0);
        end
        // grow: results held back until the longer window has filled
        write_window(swm_pkg::WLEN_W'(12));
        repeat (15) begin
            v = gen_sample(SHAPE_NARROW, v);
            send_item(v, 1'b0);
        end
        // shrink
        write_window(swm_pkg::WLEN_W'(2));
        repeat (10) begin
            v = gen_sample(SHAPE_WIDE, v);
            send_item(v, 1'b0);
        end
        // 64 falling samples fill the deque; after the cut to 2 the front
        // no longer expires, so each push overflows
        write_window(swm_pkg::WLEN_W'(swm_pkg::MAX_WINDOW));
        v = sample_t'($urandom_range(1000, 100000));
        send_item(v, 1'b1);
        repeat (69) begin
            v = gen_sample(SHAPE_FALLING, v);
            send_item(v, 1'b0);
        end
        write_window(swm_pkg::WLEN_W'(2));
        repeat (10) begin
            v = gen_sample(SHAPE_FALLING, v);
            send_item(v, 1'b0);
        end
    endtask

    // Random phases over several window lengths and traffic patterns.
    task automatic test_random();
        int      windows [8];
        shape_t  shape;
        sample_t v;
        logic    start;
        windows = '{3, 1, swm_pkg::MAX_WINDOW, 127, 0, 17, 5, 0};
        windows[7] = $urandom_range(2, swm_pkg::MAX_WINDOW - 1);
        v = '0;
        for (int p = 0; p < 8; p++) begin
            write_window(swm_pkg::WLEN_W'(windows[p]));
            gap_max  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            stall_on = ($urandom_range(0, 3) != 0);
            shape    = shape_t'($urandom_range(0, 4));
            for (int i = 0; i < 96; i++) begin
                if (p == 3 && i == 48) wait_results();
                start = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 47) == 0);
                if (start || $urandom_range(0, 15) == 0) shape = shape_t'($urandom_range(0, 4));
                v = gen_sample(shape, v);
                send_item(v, start);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_window();
        test_window_limits();
        test_window_change();
        test_random();

        wait_results();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
